>>> rtl/bfsp_pkg.sv
// Shared types, constants and codes for the box free-space placement block.
`default_nettype none
package bfsp_pkg;

	localparam int MAX_SPACES = 64;
	localparam int IDX_W      = $clog2(MAX_SPACES);
	localparam int CNT_W      = $clog2(MAX_SPACES + 1);
	localparam int DIM_W      = 11;

	localparam logic [DIM_W-1:0] RST_LENGTH = 11'd800;
	localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd1200;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd2000;

	localparam int ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_LENGTH = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_PLACED = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_APPEND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             start_packing;
		logic [DIM_W-1:0] size_x;
		logic [DIM_W-1:0] size_y;
		logic [DIM_W-1:0] size_z;
		logic [2:0]       rotation;
		logic [30:0]      box_volume;
		logic [15:0]      box_value;
	} box_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [DIM_W-1:0] pos_x;
		logic [DIM_W-1:0] pos_y;
		logic [DIM_W-1:0] pos_z;
		logic [DIM_W-1:0] placed_length;
		logic [DIM_W-1:0] placed_width;
		logic [DIM_W-1:0] placed_height;
		logic [15:0]      placed_count;
		logic [31:0]      value_total;
		logic [39:0]      volume_total;
	} result_t;

	typedef struct packed {
		logic [DIM_W-1:0] ox;
		logic [DIM_W-1:0] oy;
		logic [DIM_W-1:0] oz;
		logic [DIM_W-1:0] el;
		logic [DIM_W-1:0] ew;
		logic [DIM_W-1:0] eh;
	} space_t;

	localparam int SPACE_W = $bits(space_t);

	typedef struct packed {
		logic [DIM_W-1:0] length;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic init_wr;
		logic accept;
		logic scan;
		logic decide;
		logic shift;
		logic append;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic placeable;
		logic shift_done;
		logic append_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/bfsp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/bfsp_regs.sv
// Container size registers behind the APB-style configuration port.
`default_nettype none
module bfsp_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bfsp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	output bfsp_pkg::cfg_t                   cfg
);

	bfsp_pkg::cfg_t   cfg_q;
	bfsp_pkg::reg_idx_t idx;
	logic             wr;

	assign idx    = bfsp_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length <= bfsp_pkg::RST_LENGTH;
			cfg_q.width  <= bfsp_pkg::RST_WIDTH;
			cfg_q.height <= bfsp_pkg::RST_HEIGHT;
		end else if (wr) begin
			unique case (idx)
				bfsp_pkg::REG_LENGTH: cfg_q.length <= pwdata[bfsp_pkg::DIM_W-1:0];
				bfsp_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[bfsp_pkg::DIM_W-1:0];
				bfsp_pkg::REG_HEIGHT: cfg_q.height <= pwdata[bfsp_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			bfsp_pkg::REG_LENGTH: prdata = 32'(cfg_q.length);
			bfsp_pkg::REG_WIDTH:  prdata = 32'(cfg_q.width);
			bfsp_pkg::REG_HEIGHT: prdata = 32'(cfg_q.height);
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/bfsp_ctrl.sv
// Sequencing state machine for scan, removal, append and result hand-off.
`default_nettype none
module bfsp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          box_valid,
	output logic               box_stall,
	input  wire bfsp_pkg::sts_t sts,
	output bfsp_pkg::cmd_t     cmd
);

	bfsp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfsp_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		box_stall = 1'b1;
		unique case (state_q)
			bfsp_pkg::S_INIT: begin
				cmd.init_wr = 1'b1;
				state_d     = bfsp_pkg::S_IDLE;
			end
			bfsp_pkg::S_IDLE: begin
				box_stall = 1'b0;
				if (box_valid) begin
					cmd.accept = 1'b1;
					state_d    = bfsp_pkg::S_SCAN;
				end
			end
			bfsp_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = bfsp_pkg::S_DECIDE;
				end
			end
			bfsp_pkg::S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.placeable ? bfsp_pkg::S_SHIFT : bfsp_pkg::S_DONE;
			end
			bfsp_pkg::S_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					state_d = bfsp_pkg::S_APPEND;
				end
			end
			bfsp_pkg::S_APPEND: begin
				cmd.append = 1'b1;
				if (sts.append_last) begin
					state_d = bfsp_pkg::S_DONE;
				end
			end
			bfsp_pkg::S_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = bfsp_pkg::S_IDLE;
				end
			end
			default: state_d = bfsp_pkg::S_INIT;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/bfsp_dp.sv
// Datapath: space list memory, fit scan pipeline, list update, totals and result register.
`default_nettype none
module bfsp_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bfsp_pkg::cmd_t cmd,
	output bfsp_pkg::sts_t      sts,
	input  wire bfsp_pkg::box_t box,
	input  wire bfsp_pkg::cfg_t cfg,
	output bfsp_pkg::result_t   result,
	output logic                result_valid,
	input  wire logic           result_stall
);

	localparam int IW = bfsp_pkg::IDX_W;
	localparam int CW = bfsp_pkg::CNT_W;
	localparam int DW = bfsp_pkg::DIM_W;

	// list memory ports
	logic                   m_we, m_re;
	logic [IW-1:0]          m_wa, m_ra;
	bfsp_pkg::space_t       m_wd, m_rd;
	logic [bfsp_pkg::SPACE_W-1:0] m_rd_raw;

	// item registers
	logic [CW-1:0]          count_q;
	logic [DW-1:0]          bl_q, bw_q, bh_q;
	logic [30:0]            bvol_q;
	logic [15:0]            bval_q;
	logic [15:0]            cnt_acc_q;
	logic [31:0]            val_acc_q;
	logic [39:0]            vol_acc_q;
	logic [DW-1:0]          rl, rw, rh;

	// scan pipeline
	logic [CW-1:0]          rd_ptr_q;
	logic                   rv_q;
	logic [IW-1:0]          ridx_q;
	logic                   v_s1, fit_s1, v_s2, fit_s2;
	logic [2*DW-1:0]        prod_s1;
	logic [3*DW-1:0]        vol_s2;
	bfsp_pkg::space_t       ent_s1, ent_s2;
	logic [IW-1:0]          idx_s1, idx_s2;
	logic                   scan_issue, hit, take;

	// chosen space
	logic                   found_q;
	bfsp_pkg::space_t       best_q;
	logic [IW-1:0]          best_idx_q;
	logic [1:0]             status_q;
	logic                   full;

	// removal and append
	logic [CW-1:0]          sh_rd_q;
	logic                   sh_wv_q;
	logic [IW-1:0]          sh_wa_q;
	logic                   sh_issue;
	logic [1:0]             app_n_q;
	bfsp_pkg::space_t       rem;

	// totals arithmetic
	logic [32:0]            val_sum;
	logic [40:0]            vol_sum;

	// result register
	bfsp_pkg::result_t      out_q;
	logic                   out_valid_q;

	bfsp_ram #(
		.WIDTH(bfsp_pkg::SPACE_W),
		.DEPTH(bfsp_pkg::MAX_SPACES)
	) u_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_wa),
		.wdata(m_wd),
		.re   (m_re),
		.raddr(m_ra),
		.rdata(m_rd_raw)
	);

	assign m_rd = bfsp_pkg::space_t'(m_rd_raw);

	always_comb begin
		unique case (box.rotation)
			3'd0:    begin rl = box.size_x; rw = box.size_y; rh = box.size_z; end
			3'd1:    begin rl = box.size_y; rw = box.size_x; rh = box.size_z; end
			3'd2:    begin rl = box.size_x; rw = box.size_z; rh = box.size_y; end
			3'd3:    begin rl = box.size_y; rw = box.size_z; rh = box.size_x; end
			3'd4:    begin rl = box.size_z; rw = box.size_y; rh = box.size_x; end
			default: begin rl = box.size_z; rw = box.size_x; rh = box.size_y; end
		endcase
	end

	assign scan_issue = cmd.scan && (rd_ptr_q < count_q);
	assign sh_issue   = cmd.shift && (sh_rd_q < count_q);
	assign m_re       = scan_issue || sh_issue;
	assign m_ra       = cmd.scan ? rd_ptr_q[IW-1:0] : sh_rd_q[IW-1:0];

	always_comb begin
		unique case (app_n_q)
			2'd0: rem = '{ox: best_q.ox, oy: DW'(best_q.oy + bw_q), oz: best_q.oz,
			              el: bl_q, ew: DW'(best_q.ew - bw_q), eh: best_q.eh};
			2'd1: rem = '{ox: DW'(best_q.ox + bl_q), oy: best_q.oy, oz: best_q.oz,
			              el: DW'(best_q.el - bl_q), ew: best_q.ew, eh: best_q.eh};
			default: rem = '{ox: best_q.ox, oy: best_q.oy, oz: DW'(best_q.oz + bh_q),
			              el: bl_q, ew: bw_q, eh: DW'(best_q.eh - bh_q)};
		endcase
	end

	always_comb begin
		m_we = 1'b0;
		m_wa = '0;
		m_wd = rem;
		priority if (cmd.init_wr) begin
			m_we = 1'b1;
			m_wd = '{ox: '0, oy: '0, oz: '0, el: bfsp_pkg::RST_LENGTH,
			         ew: bfsp_pkg::RST_WIDTH, eh: bfsp_pkg::RST_HEIGHT};
		end else if (cmd.accept && box.start_packing) begin
			m_we = 1'b1;
			m_wd = '{ox: '0, oy: '0, oz: '0, el: cfg.length, ew: cfg.width, eh: cfg.height};
		end else if (cmd.shift) begin
			m_we = sh_wv_q;
			m_wa = sh_wa_q;
			m_wd = m_rd;
		end else if (cmd.append) begin
			m_we = 1'b1;
			m_wa = IW'(count_q - CW'(1)) + IW'(app_n_q);
		end
	end

	assign hit  = v_s2 && fit_s2 && (vol_s2 >= 33'(bvol_q));
	assign take = hit && (!found_q || (ent_s2.el < best_q.el));
	assign full = (32'(count_q) + 32'd2) > 32'(bfsp_pkg::MAX_SPACES);

	assign val_sum = 33'(val_acc_q) + 33'(bval_q);
	assign vol_sum = 41'(vol_acc_q) + 41'(bvol_q);

	assign sts.scan_done   = (rd_ptr_q >= count_q) && !rv_q && !v_s1 && !v_s2;
	assign sts.placeable   = found_q && !full;
	assign sts.shift_done  = (sh_rd_q >= count_q) && !sh_wv_q;
	assign sts.append_last = (app_n_q == 2'd2);
	assign sts.out_free    = !out_valid_q || !result_stall;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bl_q   <= rl;
			bw_q   <= rw;
			bh_q   <= rh;
			bvol_q <= box.box_volume;
			bval_q <= box.box_value;
		end
		ridx_q  <= rd_ptr_q[IW-1:0];
		prod_s1 <= (2*DW)'(m_rd.el) * (2*DW)'(m_rd.ew);
		fit_s1  <= (m_rd.el >= bl_q) && (m_rd.ew >= bw_q) && (m_rd.eh >= bh_q);
		ent_s1  <= m_rd;
		idx_s1  <= ridx_q;
		vol_s2  <= (3*DW)'(prod_s1) * (3*DW)'(ent_s1.eh);
		fit_s2  <= fit_s1;
		ent_s2  <= ent_s1;
		idx_s2  <= idx_s1;
		if (take) begin
			best_q     <= ent_s2;
			best_idx_q <= idx_s2;
		end
		sh_wa_q <= IW'(sh_rd_q - CW'(1));
		if (cmd.decide) begin
			status_q <= !found_q ? bfsp_pkg::ST_NOFIT :
			            (full ? bfsp_pkg::ST_FULL : bfsp_pkg::ST_PLACED);
		end
		if (cmd.emit) begin
			out_q.status        <= status_q;
			out_q.placed_count  <= cnt_acc_q;
			out_q.value_total   <= val_acc_q;
			out_q.volume_total  <= vol_acc_q;
			if (status_q == bfsp_pkg::ST_PLACED) begin
				out_q.pos_x         <= best_q.ox;
				out_q.pos_y         <= best_q.oy;
				out_q.pos_z         <= best_q.oz;
				out_q.placed_length <= bl_q;
				out_q.placed_width  <= bw_q;
				out_q.placed_height <= bh_q;
			end else begin
				out_q.pos_x         <= '0;
				out_q.pos_y         <= '0;
				out_q.pos_z         <= '0;
				out_q.placed_length <= '0;
				out_q.placed_width  <= '0;
				out_q.placed_height <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(1);
			cnt_acc_q   <= '0;
			val_acc_q   <= '0;
			vol_acc_q   <= '0;
			rd_ptr_q    <= '0;
			rv_q        <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			found_q     <= 1'b0;
			sh_rd_q     <= '0;
			sh_wv_q     <= 1'b0;
			app_n_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rv_q <= scan_issue;
			v_s1 <= rv_q;
			v_s2 <= v_s1;
			if (scan_issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.accept) begin
				rd_ptr_q <= '0;
				found_q  <= 1'b0;
				app_n_q  <= '0;
				if (box.start_packing) begin
					count_q   <= CW'(1);
					cnt_acc_q <= '0;
					val_acc_q <= '0;
					vol_acc_q <= '0;
				end
			end
			if (cmd.decide && found_q && !full) begin
				sh_rd_q <= CW'(best_idx_q) + CW'(1);
				if (cnt_acc_q != '1) begin
					cnt_acc_q <= cnt_acc_q + 16'd1;
				end
				val_acc_q <= val_sum[32] ? '1 : val_sum[31:0];
				vol_acc_q <= vol_sum[40] ? '1 : vol_sum[39:0];
			end
			sh_wv_q <= sh_issue;
			if (sh_issue) begin
				sh_rd_q <= sh_rd_q + CW'(1);
			end
			if (cmd.append) begin
				app_n_q <= app_n_q + 2'd1;
				if (app_n_q == 2'd2) begin
					count_q <= count_q + CW'(2);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/box_free_space_placement_top.sv
// Top level of the box free-space placement block.
//
//  channel   direction  handshake                   payload
//  box       in         box_valid / box_stall       bfsp_pkg::box_t
//  result    out        result_valid / result_stall bfsp_pkg::result_t
//  config    in         APB psel/penable/pwrite     container length, width, height
//
// The free-space count is odd, and at most 61 when a box is placed; an unplaced item
// skips removal and append and goes from the scan straight to its result.
// One pass reads every list entry through the fit pipeline, a second moves the tail down
// over the chosen space, each through the single read port of the list memory.
// After reset the block loads the whole container space, at its reset size, before it takes an item.
// A result waits in its output register while stalled; the block can take the next item while it waits.
`default_nettype none
module box_free_space_placement_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        box_valid,
	output logic                             box_stall,
	input  wire bfsp_pkg::box_t              box,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output bfsp_pkg::result_t                result,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bfsp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);

	bfsp_pkg::cfg_t cfg;
	bfsp_pkg::cmd_t cmd;
	bfsp_pkg::sts_t sts;

	bfsp_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	bfsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.box_valid(box_valid),
		.box_stall(box_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfsp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.box         (box),
		.cfg         (cfg),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
`default_nettype wire

>>> rtl/bfsp_chk.sv
// Port-level checker for the placement block, bound to the top level.
`default_nettype none
module bfsp_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              box_valid,
	input wire logic              box_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire bfsp_pkg::result_t result,
	input wire logic [31:0]       prdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result item changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid && !box_stall |=> box_stall)
		else $error("item taken while previous item in progress");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != bfsp_pkg::ST_PLACED) |->
		result.pos_x == '0 && result.pos_y == '0 && result.pos_z == '0 &&
		result.placed_length == '0 && result.placed_width == '0 &&
		result.placed_height == '0)
		else $error("unplaced item carries a placement");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status != 2'd3)
		else $error("invalid status code");

	a_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:bfsp_pkg::DIM_W] == '0)
		else $error("register read wider than field");

endmodule

bind box_free_space_placement_top bfsp_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.box_valid   (box_valid),
	.box_stall   (box_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.result      (result),
	.prdata      (prdata)
);
`default_nettype wire
